### rtl/chlcd_pkg.sv
package chlcd_pkg;

	localparam int unsigned PC_W  = 4;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 8;

	typedef logic [PC_W-1:0]  pc_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_CMD    = 3'd1;
	localparam logic [2:0] MODE_CHAR   = 3'd2;
	localparam logic [2:0] MODE_CURSOR = 3'd3;
	localparam logic [2:0] MODE_SHIFT  = 3'd4;
	localparam logic [2:0] MODE_GLYPH  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STROBE = 8'd3;

	localparam cnt_t GLYPH_ROWS = 4'd7;

	localparam pc_t PC_INIT   = 4'd0;
	localparam pc_t PC_CMD    = 4'd6;
	localparam pc_t PC_CHAR   = 4'd7;
	localparam pc_t PC_CURSOR = 4'd8;
	localparam pc_t PC_SHIFT  = 4'd9;
	localparam pc_t PC_GLYPH  = 4'd10;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_NIBBLE,
		COND_WIDE
	} cond_t;

	typedef enum logic [2:0] {
		SRC_CONST,
		SRC_BYTE,
		SRC_CURSOR,
		SRC_SHIFT,
		SRC_GADDR,
		SRC_GROW,
		SRC_DISPCTL
	} src_t;

	typedef struct packed {
		cond_t      cond;
		src_t       src;
		logic [7:0] konst;
		logic       rs;
		logic [4:0] settle;
		logic       single;
		logic       rep;
		logic       fin;
	} uword_t;

	typedef struct packed {
		logic       nibble;
		logic       cursor_visible;
		logic       cursor_blink;
	} cfg_t;

	typedef struct packed {
		logic       load;
		src_t       src;
		logic [7:0] konst;
		logic       rs;
		logic [4:0] settle;
		logic       lo_half;
		logic       wide;
		logic       last;
		logic       glyph_shift;
	} ctrl_t;

	function automatic uword_t ucode(input pc_t pc);
		uword_t uw;
		uw = '{cond: COND_ALWAYS, src: SRC_CONST, konst: 8'h00, rs: 1'b0, settle: 5'd0,
			single: 1'b0, rep: 1'b0, fin: 1'b1};
		unique case (pc)
			4'd0: begin
				uw.cond = COND_NIBBLE; uw.konst = 8'h20; uw.settle = 5'd31;
				uw.single = 1'b1; uw.fin = 1'b0;
			end
			4'd1: begin
				uw.cond = COND_NIBBLE; uw.konst = 8'h28; uw.fin = 1'b0;
			end
			4'd2: begin
				uw.cond = COND_WIDE; uw.konst = 8'h38; uw.settle = 5'd30; uw.fin = 1'b0;
			end
			4'd3: begin
				uw.src = SRC_DISPCTL; uw.fin = 1'b0;
			end
			4'd4: begin
				uw.konst = 8'h01; uw.settle = 5'd1; uw.fin = 1'b0;
			end
			4'd5: begin
				uw.konst = 8'h06; uw.settle = 5'd2;
			end
			4'd6: begin
				uw.src = SRC_BYTE;
			end
			4'd7: begin
				uw.src = SRC_BYTE; uw.rs = 1'b1;
			end
			4'd8: begin
				uw.src = SRC_CURSOR;
			end
			4'd9: begin
				uw.src = SRC_SHIFT; uw.rep = 1'b1;
			end
			4'd10: begin
				uw.src = SRC_GADDR; uw.fin = 1'b0;
			end
			4'd11: begin
				uw.src = SRC_GROW; uw.rs = 1'b1; uw.rep = 1'b1; uw.fin = 1'b0;
			end
			4'd12: begin
				uw.rs = 1'b1; uw.fin = 1'b0;
			end
			4'd13: begin
				uw.konst = 8'h80;
			end
			default: begin
			end
		endcase
		return uw;
	endfunction

	function automatic pc_t entry(input logic [2:0] mode);
		pc_t pc;
		unique case (mode)
			MODE_INIT:   pc = PC_INIT;
			MODE_CMD:    pc = PC_CMD;
			MODE_CHAR:   pc = PC_CHAR;
			MODE_CURSOR: pc = PC_CURSOR;
			MODE_SHIFT:  pc = PC_SHIFT;
			MODE_GLYPH:  pc = PC_GLYPH;
			default:     pc = PC_INIT;
		endcase
		return pc;
	endfunction

endpackage

### rtl/chlcd_if.sv
interface chlcd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [7:0]  byte_value;
	logic [1:0]  row;
	logic [5:0]  col;
	logic        shift_display;
	logic        shift_right;
	logic [3:0]  shift_count;
	logic [3:0]  glyph_index;
	logic [55:0] glyph_rows;

	modport source (output valid, mode, byte_value, row, col, shift_display, shift_right,
		shift_count, glyph_index, glyph_rows, input ready);
	modport sink (input valid, mode, byte_value, row, col, shift_display, shift_right,
		shift_count, glyph_index, glyph_rows, output ready);
endinterface

interface chlcd_strobe_if;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic [7:0] bus_value;
	logic [4:0] settle_ms;
	logic       last;

	modport source (output valid, reg_select, bus_value, settle_ms, last, input ready);
	modport sink (input valid, reg_select, bus_value, settle_ms, last, output ready);
endinterface

interface chlcd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [chlcd_pkg::CFG_IDX_W-1:0] index;
	logic [chlcd_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/chlcd_seq.sv
module chlcd_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_accept,
	input  logic [2:0]           mode,
	input  logic [1:0]           row,
	input  logic [5:0]           col,
	input  logic [3:0]           shift_count,
	input  logic [3:0]           glyph_index,
	input  chlcd_pkg::cfg_t      cfg,
	input  logic                 out_free,
	output logic                 req_ready,
	output chlcd_pkg::ctrl_t     ctrl
);

	logic               busy_q;
	logic               phase_q;
	chlcd_pkg::pc_t     pc_q;
	chlcd_pkg::cnt_t    cnt_q;
	chlcd_pkg::uword_t  uw;
	logic               req_ok;
	logic               cond_ok;
	logic               emit;
	logic               half_done;
	logic               step_done;
	logic               repeat_more;

	always_comb begin
		unique case (mode)
			chlcd_pkg::MODE_INIT,
			chlcd_pkg::MODE_CMD,
			chlcd_pkg::MODE_CHAR:   req_ok = 1'b1;
			chlcd_pkg::MODE_CURSOR: req_ok = !row[1] && (col[5:4] == 2'b00);
			chlcd_pkg::MODE_SHIFT:  req_ok = (shift_count != 4'd0);
			chlcd_pkg::MODE_GLYPH:  req_ok = !glyph_index[3];
			default:                req_ok = 1'b0;
		endcase
	end

	assign uw = chlcd_pkg::ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			chlcd_pkg::COND_NIBBLE: cond_ok = cfg.nibble;
			chlcd_pkg::COND_WIDE:   cond_ok = !cfg.nibble;
			default:                cond_ok = 1'b1;
		endcase
	end

	assign emit        = busy_q && cond_ok && out_free;
	assign half_done   = cfg.nibble && !uw.single && !phase_q;
	assign step_done   = busy_q && (!cond_ok || (emit && !half_done));
	assign repeat_more = uw.rep && (cnt_q != 4'd1);
	assign req_ready   = !busy_q;

	always_comb begin
		ctrl.load        = emit;
		ctrl.src         = uw.src;
		ctrl.konst       = uw.konst;
		ctrl.rs          = uw.rs;
		ctrl.settle      = phase_q ? 5'd0 : uw.settle;
		ctrl.lo_half     = phase_q;
		ctrl.wide        = !cfg.nibble;
		ctrl.last        = !half_done && uw.fin && !repeat_more;
		ctrl.glyph_shift = emit && !half_done && (uw.src == chlcd_pkg::SRC_GROW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			pc_q    <= chlcd_pkg::PC_INIT;
			cnt_q   <= '0;
		end else if (req_accept) begin
			busy_q  <= req_ok;
			phase_q <= 1'b0;
			pc_q    <= chlcd_pkg::entry(mode);
			cnt_q   <= (mode == chlcd_pkg::MODE_SHIFT) ? shift_count : chlcd_pkg::GLYPH_ROWS;
		end else begin
			if (emit) begin
				phase_q <= half_done;
			end
			if (step_done) begin
				if (!cond_ok) begin
					pc_q <= pc_q + 4'd1;
				end else if (repeat_more) begin
					cnt_q <= cnt_q - 4'd1;
				end else if (uw.fin) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + 4'd1;
				end
			end
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load && ctrl.last |=> !busy_q)
		else $error("final strobe did not end the request");

	a_phase_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> cfg.nibble)
		else $error("low nibble phase on an 8-bit bus");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && uw.rep |-> cnt_q != 4'd0)
		else $error("repeat step with an empty count");

endmodule

### rtl/chlcd_dp.sv
module chlcd_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_accept,
	input  logic [7:0]            byte_value,
	input  logic [1:0]            row,
	input  logic [5:0]            col,
	input  logic                  shift_display,
	input  logic                  shift_right,
	input  logic [3:0]            glyph_index,
	input  logic [55:0]           glyph_rows,
	input  chlcd_pkg::cfg_t       cfg,
	input  chlcd_pkg::ctrl_t      ctrl,
	output logic                  out_free,
	chlcd_strobe_if.source        strobe
);

	logic [7:0]  byte_q;
	logic        row_q;
	logic [3:0]  col_q;
	logic        sd_q;
	logic        sr_q;
	logic [2:0]  gi_q;
	logic [55:0] grow_q;
	logic [7:0]  cur_byte;
	logic [7:0]  bus_next;
	logic        out_valid_q;
	logic        rs_q;
	logic [7:0]  bus_q;
	logic [4:0]  settle_q;
	logic        last_q;

	always_comb begin
		unique case (ctrl.src)
			chlcd_pkg::SRC_BYTE:    cur_byte = byte_q;
			chlcd_pkg::SRC_CURSOR:  cur_byte = {1'b1, row_q, 2'b00, col_q};
			chlcd_pkg::SRC_SHIFT:   cur_byte = {4'h1, sd_q, sr_q, 2'b00};
			chlcd_pkg::SRC_GADDR:   cur_byte = {2'b01, gi_q, 3'b000};
			chlcd_pkg::SRC_GROW:    cur_byte = grow_q[7:0];
			chlcd_pkg::SRC_DISPCTL: cur_byte = {6'b000011, cfg.cursor_visible, cfg.cursor_blink};
			default:                cur_byte = ctrl.konst;
		endcase
	end

	always_comb begin
		if (ctrl.wide) begin
			bus_next = cur_byte;
		end else if (ctrl.lo_half) begin
			bus_next = {cur_byte[3:0], 4'h0};
		end else begin
			bus_next = {cur_byte[7:4], 4'h0};
		end
	end

	assign out_free = !out_valid_q || strobe.ready;

	always_ff @(posedge clk) begin
		if (req_accept) begin
			byte_q <= byte_value;
			row_q  <= row[0];
			col_q  <= col[3:0];
			sd_q   <= shift_display;
			sr_q   <= shift_right;
			gi_q   <= glyph_index[2:0];
			grow_q <= glyph_rows;
		end else if (ctrl.glyph_shift) begin
			grow_q <= {8'h00, grow_q[55:8]};
		end
		if (ctrl.load) begin
			rs_q     <= ctrl.rs;
			bus_q    <= bus_next;
			settle_q <= ctrl.settle;
			last_q   <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load) begin
			out_valid_q <= 1'b1;
		end else if (strobe.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign strobe.valid      = out_valid_q;
	assign strobe.reg_select = rs_q;
	assign strobe.bus_value  = bus_q;
	assign strobe.settle_ms  = settle_q;
	assign strobe.last       = last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> out_free)
		else $error("strobe loaded over one not yet taken");

	a_nibble_low: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load && !ctrl.wide |=> bus_q[3:0] == 4'h0)
		else $error("low bus bits set in nibble mode");

	a_shift_row: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.glyph_shift |-> ctrl.rs)
		else $error("glyph row sent to the command register");

endmodule

### rtl/char_lcd_write_sequencer.sv
// Character LCD write sequencer. Host requests arrive on the req channel and
// each one becomes a run of enable strobes on the strobe channel, one result
// per strobe with register select, bus value, settle time and a last flag.
// Registers are written through the cfg channel, which is always ready, and
// must only be written while no request is in flight.
// A request is decoded by a small microprogram: one control word per step,
// each step sending a byte, or a nibble pair on the 4-bit bus (init wake: one).
// The request loads the program registers, then the first strobe loads the
// output register; a new strobe follows every cycle while the receiver
// takes them and no step is skipped. Init passes one skipped step on the
// 4-bit bus and two on the 8-bit bus. A shift request gives up to 15 or 30
// strobes, a glyph definition 10 or 20. Requests with a bad position, glyph
// slot, zero shift count or unused mode are taken and give no strobe.
// req.ready is low from the cycle after a request is taken until its last
// strobe is in the output register. When the receiver stalls, the output
// register holds its strobe and the program waits on that step.
// Reset empties the output register, ends any program and loads the register
// defaults: 4-bit bus, cursor shown and blinking, strobe time 2 ms.
module char_lcd_write_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	chlcd_req_if.sink      req,
	chlcd_strobe_if.source strobe,
	chlcd_cfg_if.sink      cfg
);

	chlcd_pkg::cfg_t   cfg_q;
	chlcd_pkg::ctrl_t  ctrl;
	logic [7:0]        strobe_ms_q;
	logic              req_accept;
	logic              cfg_write;
	logic              out_free;

	assign cfg.ready  = 1'b1;
	assign cfg_write  = cfg.valid && cfg.ready;
	assign req_accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nibble         <= 1'b1;
			cfg_q.cursor_visible <= 1'b1;
			cfg_q.cursor_blink   <= 1'b1;
			strobe_ms_q          <= 8'd2;
		end else if (cfg_write) begin
			unique case (cfg.index)
				chlcd_pkg::REG_NIBBLE: cfg_q.nibble         <= cfg.data[0];
				chlcd_pkg::REG_CURSOR: cfg_q.cursor_visible <= cfg.data[0];
				chlcd_pkg::REG_BLINK:  cfg_q.cursor_blink   <= cfg.data[0];
				chlcd_pkg::REG_STROBE: strobe_ms_q          <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	chlcd_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_accept  (req_accept),
		.mode        (req.mode),
		.row         (req.row),
		.col         (req.col),
		.shift_count (req.shift_count),
		.glyph_index (req.glyph_index),
		.cfg         (cfg_q),
		.out_free    (out_free),
		.req_ready   (req.ready),
		.ctrl        (ctrl)
	);

	chlcd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_accept    (req_accept),
		.byte_value    (req.byte_value),
		.row           (req.row),
		.col           (req.col),
		.shift_display (req.shift_display),
		.shift_right   (req.shift_right),
		.glyph_index   (req.glyph_index),
		.glyph_rows    (req.glyph_rows),
		.cfg           (cfg_q),
		.ctrl          (ctrl),
		.out_free      (out_free),
		.strobe        (strobe)
	);

	a_strobe_ms_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_write && (cfg.index == chlcd_pkg::REG_STROBE)) |=> $stable(strobe_ms_q))
		else $error("strobe time changed without a write");

	a_nibble_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_write && (cfg.index == chlcd_pkg::REG_NIBBLE)) |=> $stable(cfg_q.nibble))
		else $error("bus width changed without a write");

	a_nibble_bus: assert property (@(posedge clk) disable iff (!arst_n)
		strobe.valid && cfg_q.nibble |-> strobe.bus_value[3:0] == 4'h0)
		else $error("low bus bits set on the 4-bit bus");

endmodule

### tb/tb_top.sv
module tb_top;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_REQUESTS = 62;
	localparam int PHASES         = 6;

	localparam logic [2:0] MODE_INIT   = chlcd_pkg::MODE_INIT;
	localparam logic [2:0] MODE_CMD    = chlcd_pkg::MODE_CMD;
	localparam logic [2:0] MODE_CHAR   = chlcd_pkg::MODE_CHAR;
	localparam logic [2:0] MODE_CURSOR = chlcd_pkg::MODE_CURSOR;
	localparam logic [2:0] MODE_SHIFT  = chlcd_pkg::MODE_SHIFT;
	localparam logic [2:0] MODE_GLYPH  = chlcd_pkg::MODE_GLYPH;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	localparam logic [7:0] NIBBLE_WAKE    = 8'h20;
	localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
	localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
	localparam logic [7:0] CMD_DISPCTL    = 8'h0C;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_ENTRY      = 8'h06;
	localparam logic [7:0] CMD_DDRAM_ROW0 = 8'h80;
	localparam logic [7:0] CMD_DDRAM_ROW1 = 8'hC0;
	localparam logic [7:0] CMD_SHIFT      = 8'h10;
	localparam logic [7:0] CMD_CGRAM      = 8'h40;
	localparam logic [7:0] HIGH_NIBBLE    = 8'hF0;

	localparam logic [4:0] SETTLE_WAKE_4BIT = 5'd31;
	localparam logic [4:0] SETTLE_WAKE_8BIT = 5'd30;
	localparam logic [4:0] SETTLE_CLEAR     = 5'd1;
	localparam logic [4:0] SETTLE_ENTRY     = 5'd2;

	localparam int MAX_ROW     = 1;
	localparam int MAX_COL     = 15;
	localparam int MAX_GLYPH   = 7;
	localparam int GLYPH_LINES = 7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  byte_value;
		logic [1:0]  row;
		logic [5:0]  col;
		logic        shift_display;
		logic        shift_right;
		logic [3:0]  shift_count;
		logic [3:0]  glyph_index;
		logic [55:0] glyph_rows;
	} lcd_req_t;

	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_value;
		logic [4:0] settle_ms;
		logic       last;
	} lcd_strobe_t;

	typedef struct {
		lcd_req_t   rq;
		bit         typed;
		int         n_exp;
		logic       rs;
		logic [7:0] bus0;
		logic [7:0] bus1;
	} directed_row_t;

	logic clk;
	logic arst_n;

	chlcd_req_if    req_ch();
	chlcd_strobe_if strobe_ch();
	chlcd_cfg_if    cfg_ch();

	char_lcd_write_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.strobe (strobe_ch),
		.cfg    (cfg_ch)
	);

	logic       cfg_nibble    = 1'b1;
	logic       cfg_cursor    = 1'b1;
	logic       cfg_blink     = 1'b1;
	logic [7:0] cfg_strobe_ms = 8'd2;

	lcd_strobe_t   strobes_due[$];
	lcd_strobe_t   burst[$];
	directed_row_t directed_rows[$];

	int errors    = 0;
	int cycles    = 0;
	int src_calm  = 0;
	int sink_calm = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic void stage_strobe(logic rs, logic [7:0] bus, logic [4:0] settle);
		lcd_strobe_t s;
		s.reg_select = rs;
		s.bus_value  = bus;
		s.settle_ms  = settle;
		s.last       = 1'b0;
		burst.push_back(s);
	endfunction

	function automatic void stage_byte(logic rs, logic [7:0] value, logic [4:0] settle);
		if (cfg_nibble) begin
			stage_strobe(rs, value & HIGH_NIBBLE, settle);
			stage_strobe(rs, {value[3:0], 4'b0000}, 5'd0);
		end else begin
			stage_strobe(rs, value, settle);
		end
	endfunction

	function automatic int predict_strobes(lcd_req_t r);
		logic [7:0]  cmd;
		lcd_strobe_t s;
		int          n;
		burst.delete();
		case (r.mode)
			MODE_INIT: begin
				if (cfg_nibble) begin
					stage_strobe(1'b0, NIBBLE_WAKE, SETTLE_WAKE_4BIT);
					stage_byte(1'b0, CMD_FUNC_4BIT, 5'd0);
				end else begin
					stage_byte(1'b0, CMD_FUNC_8BIT, SETTLE_WAKE_8BIT);
				end
				stage_byte(1'b0, CMD_DISPCTL | {6'b0, cfg_cursor, cfg_blink}, 5'd0);
				stage_byte(1'b0, CMD_CLEAR, SETTLE_CLEAR);
				stage_byte(1'b0, CMD_ENTRY, SETTLE_ENTRY);
			end
			MODE_CMD: stage_byte(1'b0, r.byte_value, 5'd0);
			MODE_CHAR: stage_byte(1'b1, r.byte_value, 5'd0);
			MODE_CURSOR: begin
				if (r.row <= MAX_ROW && r.col <= MAX_COL)
					stage_byte(1'b0, (r.row[0] ? CMD_DDRAM_ROW1 : CMD_DDRAM_ROW0) |
						{2'b00, r.col}, 5'd0);
			end
			MODE_SHIFT: begin
				cmd = CMD_SHIFT | {4'b0000, r.shift_display, r.shift_right, 2'b00};
				for (int i = 0; i < r.shift_count; i++)
					stage_byte(1'b0, cmd, 5'd0);
			end
			MODE_GLYPH: begin
				if (r.glyph_index <= MAX_GLYPH) begin
					stage_byte(1'b0, CMD_CGRAM | {2'b00, r.glyph_index[2:0], 3'b000}, 5'd0);
					for (int i = 0; i < GLYPH_LINES; i++)
						stage_byte(1'b1, r.glyph_rows[8*i +: 8], 5'd0);
					stage_byte(1'b1, 8'h00, 5'd0);
					stage_byte(1'b0, CMD_DDRAM_ROW0, 5'd0);
				end
			end
			default: begin
			end
		endcase
		n = burst.size();
		for (int i = 0; i < n; i++) begin
			s = burst[i];
			s.last = (i == n - 1);
			strobes_due.push_back(s);
		end
		return n;
	endfunction

	function automatic void add_row(logic [2:0] mode, logic [7:0] byte_value, logic [1:0] row,
		logic [5:0] col, logic sd, logic sr, logic [3:0] cnt, logic [3:0] gidx,
		logic [55:0] grows, bit typed, int n_exp, logic rs, logic [7:0] b0, logic [7:0] b1);
		directed_row_t d;
		d.rq.mode          = mode;
		d.rq.byte_value    = byte_value;
		d.rq.row           = row;
		d.rq.col           = col;
		d.rq.shift_display = sd;
		d.rq.shift_right   = sr;
		d.rq.shift_count   = cnt;
		d.rq.glyph_index   = gidx;
		d.rq.glyph_rows    = grows;
		d.typed            = typed;
		d.n_exp            = n_exp;
		d.rs               = rs;
		d.bus0             = b0;
		d.bus1             = b1;
		directed_rows.push_back(d);
	endfunction

	function automatic lcd_req_t rand_request();
		lcd_req_t r;
		int       pick;
		r.byte_value    = 8'($urandom);
		r.row           = 2'($urandom);
		r.col           = 6'($urandom);
		r.shift_display = 1'($urandom);
		r.shift_right   = 1'($urandom);
		r.shift_count   = 4'($urandom);
		r.glyph_index   = 4'($urandom);
		r.glyph_rows    = 56'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 8)
			r.mode = MODE_INIT;
		else if (pick < 25)
			r.mode = MODE_CMD;
		else if (pick < 45)
			r.mode = MODE_CHAR;
		else if (pick < 60)
			r.mode = MODE_CURSOR;
		else if (pick < 75)
			r.mode = MODE_SHIFT;
		else if (pick < 94)
			r.mode = MODE_GLYPH;
		else
			r.mode = $urandom_range(0, 1) ? MODE_SPARE7 : MODE_SPARE6;
		if ($urandom_range(0, 99) < 85) begin
			r.row         = 2'($urandom_range(0, MAX_ROW));
			r.col         = 6'($urandom_range(0, MAX_COL));
			r.shift_count = 4'($urandom_range(1, 15));
			r.glyph_index = 4'($urandom_range(0, MAX_GLYPH));
		end
		return r;
	endfunction

	task automatic send_request(lcd_req_t r);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= r.mode;
		req_ch.byte_value    <= r.byte_value;
		req_ch.row           <= r.row;
		req_ch.col           <= r.col;
		req_ch.shift_display <= r.shift_display;
		req_ch.shift_right   <= r.shift_right;
		req_ch.shift_count   <= r.shift_count;
		req_ch.glyph_index   <= r.glyph_index;
		req_ch.glyph_rows    <= r.glyph_rows;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			chlcd_pkg::REG_NIBBLE: cfg_nibble    = data[0];
			chlcd_pkg::REG_CURSOR: cfg_cursor    = data[0];
			chlcd_pkg::REG_BLINK:  cfg_blink     = data[0];
			chlcd_pkg::REG_STROBE: cfg_strobe_ms = data;
			default: begin
			end
		endcase
	endtask

	task automatic drain_and_settle();
		req_ch.valid <= 1'b0;
		while (strobes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          gap;
		lcd_strobe_t exp_s;
		strobe_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap > 0) begin
				strobe_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			strobe_ch.ready <= 1'b1;
			do @(posedge clk); while (!strobe_ch.valid);
			if (strobes_due.size() == 0) begin
				$error("strobe with no request pending: bus_value 0x%02h",
					strobe_ch.bus_value);
				errors++;
			end else begin
				exp_s = strobes_due.pop_front();
				if (strobe_ch.reg_select !== exp_s.reg_select) begin
					$error("reg_select: expected %0d, got %0d",
						exp_s.reg_select, strobe_ch.reg_select);
					errors++;
				end
				if (strobe_ch.bus_value !== exp_s.bus_value) begin
					$error("bus_value: expected 0x%02h, got 0x%02h",
						exp_s.bus_value, strobe_ch.bus_value);
					errors++;
				end
				if (strobe_ch.settle_ms !== exp_s.settle_ms) begin
					$error("settle_ms: expected %0d, got %0d",
						exp_s.settle_ms, strobe_ch.settle_ms);
					errors++;
				end
				if (strobe_ch.last !== exp_s.last) begin
					$error("last: expected %0d, got %0d", exp_s.last, strobe_ch.last);
					errors++;
				end
			end
		end
	end

	initial begin
		lcd_req_t    r;
		lcd_strobe_t s;
		logic        nib;
		logic        vis;
		logic        blk;
		logic [7:0]  sms;
		logic [55:0] ones;

		ones = {56{1'b1}};
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.mode          <= MODE_INIT;
		req_ch.byte_value    <= '0;
		req_ch.row           <= '0;
		req_ch.col           <= '0;
		req_ch.shift_display <= 1'b0;
		req_ch.shift_right   <= 1'b0;
		req_ch.shift_count   <= '0;
		req_ch.glyph_index   <= '0;
		req_ch.glyph_rows    <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= chlcd_pkg::REG_NIBBLE;
		cfg_ch.data          <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests run with the register defaults: 4-bit bus, so every
		// byte but the init wake nibble arrives as a high and a low nibble strobe.
		add_row(MODE_INIT,   8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_CMD,    8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 1, 2, 0, 8'h00, 8'h00);
		add_row(MODE_CMD,    8'hFF, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 1, 2, 0, 8'hF0, 8'hF0);
		add_row(MODE_CHAR,   8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 1, 2, 1, 8'h00, 8'h00);
		add_row(MODE_CHAR,   8'hFF, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 1, 2, 1, 8'hF0, 8'hF0);
		add_row(MODE_CHAR,   8'h5A, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_CURSOR, 8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 1, 2, 0, 8'h80, 8'h00);
		add_row(MODE_CURSOR, 8'h00, 2'd1, 6'd15, 0, 0, 4'd0,  4'd0,  '0, 1, 2, 0, 8'hC0, 8'hF0);
		add_row(MODE_CURSOR, 8'h00, 2'd2, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_CURSOR, 8'h00, 2'd0, 6'd16, 0, 0, 4'd0,  4'd0,  '0, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_CURSOR, 8'h00, 2'd3, 6'd63, 0, 0, 4'd0,  4'd0,  '0, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_SHIFT,  8'h00, 2'd0, 6'd0,  1, 1, 4'd0,  4'd0,  '0, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_SHIFT,  8'h00, 2'd0, 6'd0,  0, 0, 4'd1,  4'd0,  '0, 1, 2, 0, 8'h10, 8'h00);
		add_row(MODE_SHIFT,  8'h00, 2'd0, 6'd0,  0, 1, 4'd1,  4'd0,  '0, 1, 2, 0, 8'h10, 8'h40);
		add_row(MODE_SHIFT,  8'h00, 2'd0, 6'd0,  1, 0, 4'd2,  4'd0,  '0, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_SHIFT,  8'h00, 2'd0, 6'd0,  1, 1, 4'd15, 4'd0,  '0, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_GLYPH,  8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd0,  '0, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_GLYPH,  8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd7,  ones, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_GLYPH,  8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd3,
			56'h01_2345_6789_ABCD, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_GLYPH,  8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd8,  ones, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_GLYPH,  8'h00, 2'd0, 6'd0,  0, 0, 4'd0,  4'd15, ones, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_SPARE6, 8'hFF, 2'd3, 6'd63, 1, 1, 4'd15, 4'd7,  ones, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_SPARE7, 8'hFF, 2'd1, 6'd5,  1, 1, 4'd15, 4'd0,  ones, 1, 0, 0, 8'h00, 8'h00);
		add_row(MODE_CMD,    8'h3C, 2'd3, 6'd63, 1, 1, 4'd15, 4'd15, ones, 0, 0, 0, 8'h00, 8'h00);
		add_row(MODE_INIT,   8'hFF, 2'd3, 6'd63, 1, 1, 4'd15, 4'd15, ones, 0, 0, 0, 8'h00, 8'h00);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].rq);
			if (directed_rows[i].typed) begin
				if (directed_rows[i].n_exp > 0) begin
					s.reg_select = directed_rows[i].rs;
					s.settle_ms  = 5'd0;
					s.bus_value  = directed_rows[i].bus0;
					s.last       = (directed_rows[i].n_exp == 1);
					strobes_due.push_back(s);
				end
				if (directed_rows[i].n_exp > 1) begin
					s.bus_value = directed_rows[i].bus1;
					s.last      = 1'b1;
					strobes_due.push_back(s);
				end
			end else begin
				void'(predict_strobes(directed_rows[i].rq));
			end
		end
		drain_and_settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			nib = 1'($urandom);
			vis = 1'($urandom);
			blk = 1'($urandom);
			sms = 8'($urandom);
			case (ph)
				0: begin
					nib = 1'b0; vis = 1'b0; blk = 1'b0; sms = 8'd0;
				end
				1: begin
					nib = 1'b1; vis = 1'b1; blk = 1'b0; sms = 8'd255;
				end
				2: begin
					nib = 1'b0; vis = 1'b1; blk = 1'b1; sms = 8'd1;
				end
				3: begin
					nib = 1'b1; vis = 1'b0; blk = 1'b1;
				end
				default: begin
				end
			endcase
			if (ph == 0 || ph == 4)
				write_reg(chlcd_pkg::REG_STROBE + 8'($urandom_range(1, 252)), 8'($urandom));
			write_reg(chlcd_pkg::REG_NIBBLE, {7'($urandom), nib});
			write_reg(chlcd_pkg::REG_CURSOR, {7'($urandom), vis});
			write_reg(chlcd_pkg::REG_BLINK,  {7'($urandom), blk});
			write_reg(chlcd_pkg::REG_STROBE, sms);
			cfg_ch.valid <= 1'b0;

			for (int k = 0; k < PHASE_REQUESTS; k++) begin
				r = rand_request();
				send_request(r);
				void'(predict_strobes(r));
			end
			drain_and_settle();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
rtl/chlcd_pkg.sv
rtl/chlcd_if.sv
rtl/chlcd_seq.sv
rtl/chlcd_dp.sv
rtl/char_lcd_write_sequencer.sv
tb/tb_top.sv
